FILE: src/ssq_pkg.sv
// Shared types, codes and sizes of the severity sorted queue.
package ssq_pkg;

  // Number of record cells in the chain.
  localparam int unsigned Capacity = 32;
  // Width of a counter that can hold the capacity itself.
  localparam int unsigned CntW = $clog2(Capacity + 1);
  // Width of an index into the chain.
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;

  // Valid severity range; the most severe level is the lowest.
  localparam logic [3:0] SevMin    = 4'd1;
  localparam logic [3:0] SevMax    = 4'd5;
  localparam logic [2:0] SevSevere = 3'd1;
  localparam int unsigned NumLevels = 5;

  typedef enum logic [1:0] {
    ACT_INSERT      = 2'd0,
    ACT_LIST_ALL    = 2'd1,
    ACT_LIST_SEVERE = 2'd2,
    ACT_NONE        = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_SEV   = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_NO_SEVERE = 3'd4
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_LIST = 1'b1
  } fsm_e;

  // One stored record.
  typedef struct packed {
    logic [31:0]        id;
    logic signed [15:0] age;
    logic [2:0]         sev;
  } rec_t;

  // Control that the sequencer broadcasts to every cell.
  typedef struct packed {
    logic ins;
    logic rot;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        patient_id;
    logic signed [15:0] patient_age;
    logic [3:0]         severity_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        out_id;
    logic signed [15:0] out_age;
    logic [2:0]         out_severity;
    logic [5:0]         count_level1;
    logic [5:0]         count_level2;
    logic [5:0]         count_level3;
    logic [5:0]         count_level4;
    logic [5:0]         count_level5;
    logic               last;
  } out_item_t;

endpackage

FILE: src/ssq_cell.sv
// One cell of the sorted record chain.
module ssq_cell (
  input  logic               clk_i,
  input  ssq_pkg::cell_ctrl_t ctrl_i,
  input  logic               valid_i,
  input  ssq_pkg::rec_t      new_i,
  input  ssq_pkg::rec_t      prev_i,
  input  logic               prev_shift_i,
  input  ssq_pkg::rec_t      next_i,
  input  logic               next_valid_i,
  input  ssq_pkg::rec_t      head_i,
  output ssq_pkg::rec_t      rec_o,
  output logic               shift_o
);

  ssq_pkg::rec_t rec_q, rec_d;

  // The new record lands in front of every record that is strictly less severe.
  assign shift_o = !valid_i || (rec_q.sev > new_i.sev);

  // Insert moves the tail up by one; rotate moves every valid record down by one
  // and the last valid cell picks up the head record.
  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.ins && shift_o) begin
      rec_d = prev_shift_i ? prev_i : new_i;
    end else if (ctrl_i.rot && valid_i) begin
      rec_d = next_valid_i ? next_i : head_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

FILE: src/severity_sorted_queue_top.sv
// Top level of the severity sorted queue: cell chain and list sequencer.
//
// Usage: items enter on in_item_i under in_valid_i / in_stall_o and results
// leave on out_item_o under out_valid_o / out_stall_i. An item moves at a
// clock edge with valid high and stall low.
// An insert is applied to the cell chain in the cycle it is accepted, and its
// single status result appears in the output register in the next cycle.
// A list request walks the chain by rotating it one record per cycle towards
// cell 0, which is read out, pausing while a record waits on a stalled output;
// the rotation returns the chain to its original order at the end.
// Severity-1 records sit at the front, so a severe list emits during its first
// steps and then finishes the rotation silently. Empty, no-severe and unused
// requests give one result in the next cycle.
// Throughput: one insert per cycle while the output is taken; a list blocks
// new items until its rotation completes.
// A stalled output holds its result and pauses the list rotation while records
// remain to be emitted; the silent tail of a severe list runs on regardless.
// Reset empties the queue and clears all counts; record contents are not reset.
module severity_sorted_queue_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ssq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ssq_pkg::out_item_t out_item_o
);

  localparam int unsigned Cap  = ssq_pkg::Capacity;
  localparam int unsigned CntW = ssq_pkg::CntW;

  ssq_pkg::fsm_e      state_q, state_d;
  logic [CntW-1:0]    step_q, step_d;
  logic [CntW-1:0]    emit_n_q, emit_n_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic [CntW-1:0]    lvl_q [ssq_pkg::NumLevels];
  logic [CntW-1:0]    lvl_d [ssq_pkg::NumLevels];
  ssq_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  ssq_pkg::cell_ctrl_t ctrl;
  ssq_pkg::rec_t       new_rec;
  ssq_pkg::rec_t       rec   [Cap];
  logic                shift [Cap];
  logic                occ   [Cap];

  logic can_load;
  logic accept;
  logic sev_bad;
  logic full;

  assign can_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ssq_pkg::FSM_IDLE) || !can_load;
  assign accept     = in_valid_i && !in_stall_o;

  assign sev_bad = (in_item_i.severity_level < ssq_pkg::SevMin) ||
                   (in_item_i.severity_level > ssq_pkg::SevMax);
  assign full    = (fill_q == CntW'(Cap));

  assign new_rec.id  = in_item_i.patient_id;
  assign new_rec.age = in_item_i.patient_age;
  assign new_rec.sev = in_item_i.severity_level[2:0];

  // Cell chain; occupancy follows from the fill count.
  for (genvar i = 0; i < Cap; i++) begin : g_cell
    ssq_pkg::rec_t prev_rec;
    ssq_pkg::rec_t next_rec;
    logic          prev_shift;
    logic          next_valid;

    assign occ[i] = (CntW'(i) < fill_q);

    if (i == 0) begin : g_first
      assign prev_rec   = '0;
      assign prev_shift = 1'b0;
    end else begin : g_mid
      assign prev_rec   = rec[i-1];
      assign prev_shift = shift[i-1];
    end

    if (i == Cap - 1) begin : g_last
      assign next_rec   = '0;
      assign next_valid = 1'b0;
    end else begin : g_notlast
      assign next_rec   = rec[i+1];
      assign next_valid = occ[i+1];
    end

    ssq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (occ[i]),
      .new_i        (new_rec),
      .prev_i       (prev_rec),
      .prev_shift_i (prev_shift),
      .next_i       (next_rec),
      .next_valid_i (next_valid),
      .head_i       (rec[0]),
      .rec_o        (rec[i]),
      .shift_o      (shift[i])
    );
  end

  // Sequencer: accepts items, updates counts and walks the chain for lists.
  always_comb begin
    logic emit;
    state_d     = state_q;
    step_d      = step_q;
    emit_n_d    = emit_n_q;
    fill_d      = fill_q;
    lvl_d       = lvl_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctrl        = '0;
    emit        = 1'b0;

    case (state_q)
      ssq_pkg::FSM_IDLE: begin
        if (accept) begin
          out_d        = '0;
          out_d.last   = 1'b1;
          out_d.status = ssq_pkg::STAT_OK;
          out_valid_d  = 1'b1;
          case (in_item_i.action)
            ssq_pkg::ACT_INSERT: begin
              if (sev_bad) begin
                out_d.status = ssq_pkg::STAT_BAD_SEV;
              end else if (full) begin
                out_d.status = ssq_pkg::STAT_FULL;
              end else begin
                ctrl.ins = 1'b1;
                fill_d   = fill_q + 1'b1;
                for (int k = 0; k < ssq_pkg::NumLevels; k++) begin
                  if (new_rec.sev == 3'(k + 1)) begin
                    lvl_d[k] = lvl_q[k] + 1'b1;
                  end
                end
              end
            end
            ssq_pkg::ACT_LIST_ALL, ssq_pkg::ACT_LIST_SEVERE: begin
              if (fill_q == '0) begin
                out_d.status = ssq_pkg::STAT_EMPTY;
              end else if ((in_item_i.action == ssq_pkg::ACT_LIST_SEVERE) &&
                           (lvl_q[0] == '0)) begin
                out_d.status = ssq_pkg::STAT_NO_SEVERE;
              end else begin
                out_valid_d = out_valid_q && out_stall_i;
                out_d       = out_q;
                state_d     = ssq_pkg::FSM_LIST;
                step_d      = '0;
                emit_n_d    = (in_item_i.action == ssq_pkg::ACT_LIST_ALL) ?
                              fill_q : lvl_q[0];
              end
            end
            default: begin
              out_d.status = ssq_pkg::STAT_OK;
            end
          endcase
        end
      end
      ssq_pkg::FSM_LIST: begin
        emit = (step_q < emit_n_q);
        if (!emit || can_load) begin
          ctrl.rot = 1'b1;
          if (emit) begin
            out_d.status       = ssq_pkg::STAT_OK;
            out_d.out_id       = rec[0].id;
            out_d.out_age      = rec[0].age;
            out_d.out_severity = rec[0].sev;
            out_d.last         = (step_q == emit_n_q - 1'b1);
            out_valid_d        = 1'b1;
          end
          step_d = step_q + 1'b1;
          if (step_q == fill_q - 1'b1) begin
            state_d = ssq_pkg::FSM_IDLE;
          end
        end
      end
      default: begin
        state_d = ssq_pkg::FSM_IDLE;
      end
    endcase

    // Every result carries the counts as they stand after the item.
    out_d.count_level1 = 6'(lvl_d[0]);
    out_d.count_level2 = 6'(lvl_d[1]);
    out_d.count_level3 = 6'(lvl_d[2]);
    out_d.count_level4 = 6'(lvl_d[3]);
    out_d.count_level5 = 6'(lvl_d[4]);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssq_pkg::FSM_IDLE;
      step_q      <= '0;
      emit_n_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < ssq_pkg::NumLevels; k++) begin
        lvl_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      emit_n_q    <= emit_n_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      lvl_q       <= lvl_d;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
